[hw/rtl/text_console_writer_assert.svh]
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define TCW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("tcw assertion failed");

// Check that a condition is followed by a consequence in the next cycle.
`define TCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tcw assertion failed");

`else

`define TCW_ASSERT(lbl, clk, rstn, prop)
`define TCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Geometry, codes, transaction payloads and controller/datapath interface.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned MOVE_COUNT = COLUMNS * (ROWS - 1);
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);

  // Field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned INDEX_W = 11;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ATTR_W  = 8;

  localparam int unsigned TAB_STOP = 8;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  // Register port
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned REG_IDX_LSB = 2;
  localparam int unsigned REG_IDX_W   = APB_ADDR_W - REG_IDX_LSB;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TEXT_ATTRIBUTE = '0
  } reg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;
  } in_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic              scrolled;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MOVE,
    ST_MOVE_LAST,
    ST_FILL
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MOVE,
    OP_MOVE_LAST,
    OP_FILL
  } sweep_op_e;

  // Controller to datapath
  typedef struct packed {
    logic      take;         // input transaction accepted this cycle
    logic      sweep_rst;    // restart the sweep counter at zero
    sweep_op_e op;           // sweep operation for this cycle
    logic      load_read;    // result carries the cell read last cycle
    logic      load_result;  // load the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_e kind;      // kind of the pending input transaction
    logic  scroll;    // pending put scrolls the screen
    logic  move_end;  // sweep at the last source row cell
    logic  fill_end;  // sweep at the last cell of the screen
  } dp_stat_t;

endpackage

[hw/rtl/tcw_ram.sv]
// ----------------------------------------------------------------------------
// Text console writer RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 2000,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences puts, reads, scroll sweeps and clear sweeps; owns result valid.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_ctrl import tcw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  logic    in_ready;
  dp_cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd      = '0;
    in_ready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // take a new transaction once the result slot is free or being freed
        in_ready = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready) begin
          cmd.take = 1'b1;
          case (stat_i.kind)
            KIND_PUT: begin
              if (stat_i.scroll) begin
                cmd.sweep_rst = 1'b1;
                state_d       = ST_MOVE;
              end else begin
                cmd.load_result = 1'b1;
              end
            end
            KIND_CLEAR: begin
              cmd.sweep_rst = 1'b1;
              state_d       = ST_FILL;
            end
            KIND_READ: begin
              state_d = ST_READ;
            end
            default: begin
              cmd.load_result = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.load_read   = 1'b1;
        cmd.load_result = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_MOVE: begin
        cmd.op = OP_MOVE;
        if (stat_i.move_end) begin
          state_d = ST_MOVE_LAST;
        end
      end
      ST_MOVE_LAST: begin
        cmd.op  = OP_MOVE_LAST;
        state_d = ST_FILL;
      end
      ST_FILL: begin
        cmd.op = OP_FILL;
        if (stat_i.fill_end) begin
          cmd.load_result = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `TCW_ASSERT(a_no_result_overwrite, clk_i, rst_ni, cmd.load_result |-> (!out_valid_q || out_ready_i))
  `TCW_ASSERT_NEXT(a_clear_fills, clk_i, rst_ni, cmd.take && stat_i.kind == KIND_CLEAR, state_q == ST_FILL)
  `TCW_ASSERT_NEXT(a_move_then_fill, clk_i, rst_ni, state_q == ST_MOVE_LAST, state_q == ST_FILL)

endmodule

[hw/rtl/tcw_dp.sv]
// ----------------------------------------------------------------------------
// Text console writer datapath
// Cell memory, cursor, attribute register, sweep counter and result register.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_dp import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  in_t               in_data_i,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  output out_t              out_data_o,
  input  logic              attr_we_i,
  input  logic [ATTR_W-1:0] attr_wdata_i,
  output logic [ATTR_W-1:0] attr_o
);

  logic [ATTR_W-1:0] attr_q;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              scroll_q, scroll_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic              idx_ok_q;
  out_t              out_q;

  logic [ADDR_W-1:0] pos;
  logic [COL_W:0]    col_nx;
  logic [ROW_W:0]    row_nx;
  logic              need_scroll;
  logic              put_we;
  logic [ADDR_W-1:0] put_addr;
  logic [CELL_W-1:0] put_data;
  logic [CELL_W-1:0] blank;
  logic              idx_ok;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign blank  = {attr_q, CHAR_SPACE};
  assign pos    = ADDR_W'(int'(row_q) * COLUMNS + int'(col_q));
  assign idx_ok = (in_data_i.cell_index < INDEX_W'(CELL_COUNT));

  // Cursor motion and cell write for a put
  always_comb begin
    col_nx      = {1'b0, col_q};
    row_nx      = {1'b0, row_q};
    put_we      = 1'b0;
    put_addr    = pos;
    put_data    = {attr_q, in_data_i.char_code};
    need_scroll = 1'b0;
    case (in_data_i.char_code)
      CHAR_LF: begin
        col_nx = '0;
        row_nx = row_nx + 1'b1;
      end
      CHAR_CR: begin
        col_nx = '0;
      end
      CHAR_TAB: begin
        col_nx = (col_nx + (COL_W+1)'(TAB_STOP)) & ~(COL_W+1)'(TAB_STOP - 1);
      end
      CHAR_BS: begin
        // column zero stays put, nothing is blanked
        if (col_q != '0) begin
          col_nx   = col_nx - 1'b1;
          put_we   = 1'b1;
          put_addr = pos - 1'b1;
          put_data = blank;
        end
      end
      default: begin
        put_we = 1'b1;
        col_nx = col_nx + 1'b1;
      end
    endcase
    if (col_nx >= (COL_W+1)'(COLUMNS)) begin
      col_nx = '0;
      row_nx = row_nx + 1'b1;
    end
    if (row_nx >= (ROW_W+1)'(ROWS)) begin
      need_scroll = 1'b1;
      row_nx      = (ROW_W+1)'(ROWS - 1);
    end
  end

  always_comb begin
    row_d    = row_q;
    col_d    = col_q;
    scroll_d = scroll_q;
    if (cmd_i.take) begin
      case (in_data_i.kind)
        KIND_PUT: begin
          row_d    = row_nx[ROW_W-1:0];
          col_d    = col_nx[COL_W-1:0];
          scroll_d = need_scroll;
        end
        KIND_CLEAR: begin
          row_d    = '0;
          col_d    = '0;
          scroll_d = 1'b0;
        end
        default: begin
          scroll_d = 1'b0;
        end
      endcase
    end
  end

  // Memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = put_addr;
    ram_wdata = put_data;
    ram_raddr = sweep_q + ADDR_W'(COLUMNS);
    if (cmd_i.take) begin
      if (in_data_i.kind == KIND_PUT) begin
        ram_we = put_we;
      end
      ram_raddr = idx_ok ? ADDR_W'(in_data_i.cell_index) : '0;
    end
    case (cmd_i.op)
      OP_MOVE: begin
        // copy one row up: the cell read last cycle lands one row above
        ram_we    = (sweep_q != '0);
        ram_waddr = sweep_q - 1'b1;
        ram_wdata = ram_rdata;
      end
      OP_MOVE_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q - 1'b1;
        ram_wdata = ram_rdata;
      end
      OP_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = blank;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cmd_i.sweep_rst) begin
      sweep_d = '0;
    end else if (cmd_i.op == OP_MOVE || cmd_i.op == OP_FILL) begin
      sweep_d = sweep_q + 1'b1;
    end else begin
      sweep_d = sweep_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q   <= ATTR_RESET;
      row_q    <= '0;
      col_q    <= '0;
      scroll_q <= 1'b0;
      sweep_q  <= '0;
    end else begin
      if (attr_we_i) begin
        attr_q <= attr_wdata_i;
      end
      row_q    <= row_d;
      col_q    <= col_d;
      scroll_q <= scroll_d;
      sweep_q  <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      idx_ok_q <= idx_ok;
    end
    if (cmd_i.load_result) begin
      out_q.cell_value    <= (cmd_i.load_read && idx_ok_q) ? ram_rdata : '0;
      out_q.cursor_row    <= row_d;
      out_q.cursor_column <= col_d;
      out_q.scrolled      <= scroll_d;
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign stat_o.kind     = in_data_i.kind;
  assign stat_o.scroll   = need_scroll;
  assign stat_o.move_end = (sweep_q == ADDR_W'(MOVE_COUNT - 1));
  assign stat_o.fill_end = (sweep_q == ADDR_W'(CELL_COUNT - 1));
  assign out_data_o      = out_q;
  assign attr_o          = attr_q;

  `TCW_ASSERT(a_cursor_range, clk_i, rst_ni, (row_q < ROW_W'(ROWS)) && (col_q < COL_W'(COLUMNS)))
  `TCW_ASSERT_NEXT(a_clear_homes, clk_i, rst_ni, cmd_i.take && in_data_i.kind == KIND_CLEAR, row_q == '0 && col_q == '0)
  `TCW_ASSERT(a_move_last_pos, clk_i, rst_ni, (cmd_i.op == OP_MOVE_LAST) |-> (sweep_q == ADDR_W'(MOVE_COUNT)))

endmodule

[hw/rtl/text_console_writer.sv]
// ----------------------------------------------------------------------------
// Text console writer
// 80x25 text cell screen with cursor, wrap, scroll, clear and cell read.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                   Payload
//   in        sink       in_valid_i / in_ready_o     in_data_i  (in_t)
//   out       source     out_valid_o / out_ready_i   out_data_o (out_t)
//   config    sink       APB psel/penable/pready     pwdata / prdata, paddr
//
// Sequence per transaction, set by the single write port of the cell memory:
//   put without scroll: result loaded as it is taken; read: registered memory read, then result;
//   put that scrolls: the MOVE_COUNT cells below the top row moved up,
//   one cell moved per cycle, then the bottom row blanked;
//   clear: all CELL_COUNT cells blanked, one cell blanked per cycle.
// Reset homes the cursor and loads attribute 0x0F; cell contents stay
//   unknown until the first clear.
// A stalled result holds in the output register; a new transaction is taken
//   in the cycle that result leaves.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input transactions
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  // Result transactions
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  // Register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic              attr_hit;
  logic              attr_we;
  logic [ATTR_W-1:0] attr;

  // Decode the register index from the word address; byte lanes are ignored.
  assign attr_hit = (paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_TEXT_ATTRIBUTE);
  // Write in the access phase; the port never inserts wait states.
  assign attr_we  = psel && penable && pwrite && attr_hit;
  assign pready   = 1'b1;
  assign prdata   = attr_hit ? APB_DATA_W'(attr) : '0;

  // Controller: accepts transactions and runs the sweeps.
  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: cell memory, cursor and result register.
  tcw_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (in_data_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_data_o   (out_data_o),
    .attr_we_i    (attr_we),
    .attr_wdata_i (pwdata[ATTR_W-1:0]),
    .attr_o       (attr)
  );

endmodule

[tb/tcw_check_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer checking package
// Screen predictor and result scoreboard used by the testbench top.
// ----------------------------------------------------------------------------
package tcw_check_pkg;
  import tcw_pkg::*;

  localparam int unsigned SHOW_LIMIT = 10;

  class console_mirror;
    logic [CELL_W-1:0] screen [CELL_COUNT];
    logic [ATTR_W-1:0] attr;
    int                cur_row;
    int                cur_col;
    out_t              due_reports[$];
    int                errors;
    int                shown;

    function new();
      foreach (screen[i]) screen[i] = '0;
      attr    = ATTR_RESET;
      cur_row = 0;
      cur_col = 0;
      errors  = 0;
      shown   = 0;
    endfunction

    function logic [CELL_W-1:0] blank_cell();
      return {attr, CHAR_SPACE};
    endfunction

    // Move every row up by one and blank the bottom row.
    function void roll_up();
      for (int i = 0; i < MOVE_COUNT; i++) screen[i] = screen[i + COLUMNS];
      for (int i = MOVE_COUNT; i < CELL_COUNT; i++) screen[i] = blank_cell();
      cur_row = ROWS - 1;
    endfunction

    // Apply one character at the cursor; return 1 when the screen rolled.
    function bit place_char(logic [CHAR_W-1:0] ch);
      int pos;
      bit rolled;
      rolled = 1'b0;
      pos    = cur_row * COLUMNS + cur_col;
      case (ch)
        CHAR_LF: begin
          cur_col = 0;
          cur_row++;
        end
        CHAR_CR:  cur_col = 0;
        CHAR_TAB: cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
        CHAR_BS: begin
          if (cur_col > 0) begin
            cur_col--;
            screen[pos - 1] = blank_cell();
          end
        end
        default: begin
          screen[pos] = {attr, ch};
          cur_col++;
        end
      endcase
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= ROWS) begin
        roll_up();
        rolled = 1'b1;
      end
      return rolled;
    endfunction

    // Update the shadow screen for an accepted transaction and queue its result.
    function void note_item(in_t item);
      out_t r;
      r = '0;
      case (item.kind)
        KIND_PUT: r.scrolled = place_char(item.char_code);
        KIND_CLEAR: begin
          foreach (screen[i]) screen[i] = blank_cell();
          cur_row = 0;
          cur_col = 0;
        end
        KIND_READ: begin
          if (item.cell_index < CELL_COUNT) r.cell_value = screen[item.cell_index];
        end
        default: ;
      endcase
      r.cursor_row    = ROW_W'(cur_row);
      r.cursor_column = COL_W'(cur_col);
      due_reports.push_back(r);
    endfunction

    function void flag(string msg);
      errors++;
      if (shown < SHOW_LIMIT) begin
        shown++;
        $display("[%0t] %s", $time, msg);
      end
    endfunction

    function void compare_field(string what, int unsigned want, int unsigned got);
      if (want != got)
        flag($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", what, want, got));
    endfunction

    function void check_report(out_t got);
      out_t want;
      if (due_reports.size() == 0) begin
        flag($sformatf("result 0x%0h arrived with none awaited", got));
        return;
      end
      want = due_reports.pop_front();
      compare_field("cell_value", want.cell_value, got.cell_value);
      compare_field("cursor_row", want.cursor_row, got.cursor_row);
      compare_field("cursor_column", want.cursor_column, got.cursor_column);
      compare_field("scrolled", want.scrolled, got.scrolled);
    endfunction

    function void check_drained();
      if (due_reports.size() != 0)
        flag($sformatf("%0d results never arrived", due_reports.size()));
      errors += (due_reports.size() > 1) ? due_reports.size() - 1 : 0;
    endfunction
  endclass

endpackage

[tb/tb_text_console_writer.sv]
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, clear, read and ignored transactions through the stream port,
// rewrites the text attribute between phases, and checks every result
// against a shadow screen with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;
  import tcw_check_pkg::*;

  localparam int unsigned HALF_PERIOD = 2;
  localparam int unsigned RESET_CYCLES = 3;
  // Worst case: every transaction a full-screen sweep plus both stall draws,
  // then taken a few times over.
  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int unsigned TAIL_CYCLES = 2100;
  localparam int unsigned PHASE_ITEMS = 270;
  localparam int unsigned HOLD_AT = 100;
  // Longer than the slowest sweep, so the output register fills even when
  // the hold-off starts in the middle of a clear or a scroll.
  localparam int unsigned HOLD_CYCLES = 5000;
  localparam int unsigned MAX_GAP = 8;
  localparam int unsigned INDEX_MAX = (1 << INDEX_W) - 1;
  // The one kind code the block ignores.
  localparam kind_e KIND_SPARE = kind_e'(2'd3);

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  console_mirror mirror = new();

  int unsigned sent_count = 0;
  int unsigned ready_gap = 0;
  bit          hold_out = 1'b0;
  bit          rx_calm = 1'b0;
  bit          tx_calm = 1'b0;

  text_console_writer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // Hang guard: count cycles and give up well past the slowest correct run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  // Drive ready from the countdown at the falling edge; hold it low while
  // the long hold-off is active.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && !hold_out && (ready_gap == 0);
  end

  // Sample results at the rising edge, then draw the next stall length.
  // A calm stretch draws no stall at all.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      mirror.check_report(out_data_o);
      ready_gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
    end else if (ready_gap > 0) begin
      ready_gap--;
    end
  end

  // Long hold-off on the result side while the sender keeps offering, so the
  // output register fills and the block stops taking input.
  initial begin
    wait (sent_count >= HOLD_AT);
    @(posedge clk_i);
    hold_out = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_out = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Input side; every task starts and ends at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_item(input in_t item);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    // Hold the transaction until it is taken.
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    mirror.note_item(item);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (mirror.due_reports.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle; pready is always high.
  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(REG_TEXT_ATTRIBUTE) << REG_IDX_LSB;
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mirror.attr = value;
  endtask

  // Mostly printable text, sometimes any byte at all.
  function automatic logic [CHAR_W-1:0] text_byte();
    if ($urandom_range(0, 9) < 8) return CHAR_W'($urandom_range(32, 126));
    return CHAR_W'($urandom);
  endfunction

  // Unused fields carry random bits so they are shown to be ignored.
  function automatic in_t put_item(input logic [CHAR_W-1:0] ch);
    in_t item;
    item.kind       = KIND_PUT;
    item.char_code  = ch;
    item.cell_index = INDEX_W'($urandom);
    return item;
  endfunction

  function automatic in_t read_item(input int unsigned index);
    in_t item;
    item.kind       = KIND_READ;
    item.char_code  = CHAR_W'($urandom);
    item.cell_index = INDEX_W'(index);
    return item;
  endfunction

  function automatic in_t plain_item(input kind_e kind);
    in_t item;
    item            = in_t'($bits(in_t)'($urandom));
    item.kind       = kind;
    return item;
  endfunction

  // Read index: mostly on screen, now and then past the last cell.
  function automatic int unsigned pick_index();
    if ($urandom_range(0, 9) == 0) return $urandom_range(CELL_COUNT, INDEX_MAX);
    return $urandom_range(0, CELL_COUNT - 1);
  endfunction

  // One random phase: mostly lines of text with tabs, backspaces and reads
  // mixed in, ended by newline or carriage return so the cursor walks down
  // and the screen scrolls; the rest is clears, ignored kinds and raw noise.
  task automatic run_phase(input int unsigned target);
    int unsigned done;
    int unsigned pick;
    int unsigned len;
    int unsigned r;
    in_t         noise;
    done = 0;
    while (done < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_item(plain_item(KIND_CLEAR));
        done++;
      end else if (pick < 10) begin
        send_item(plain_item(KIND_SPARE));
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 6)) begin
          noise = in_t'($bits(in_t)'($urandom));
          send_item(noise);
          if (noise.kind != KIND_SPARE) done++;
        end
      end else begin
        // Short lines dominate; long ones run past the right edge and wrap.
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100)
                                          : $urandom_range(0, 20);
        repeat (len) begin
          r = $urandom_range(0, 29);
          if (r == 0)     send_item(put_item(CHAR_TAB));
          else if (r == 1) send_item(put_item(CHAR_BS));
          else if (r < 4)  send_item(read_item(pick_index()));
          else             send_item(put_item(text_byte()));
        end
        done += len;
        r = $urandom_range(0, 19);
        if (r < 3) begin
          send_item(put_item(CHAR_CR));
          send_item(put_item(CHAR_LF));
          done += 2;
        end else if (r < 5) begin
          send_item(put_item(CHAR_CR));
          done++;
        end else if (r >= 7) begin
          send_item(put_item(CHAR_LF));
          done++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset attribute. Clear first: the cells are
    // unknown until then.
    send_item(plain_item(KIND_CLEAR));
    send_item(put_item(8'h41));
    send_item(put_item(8'h00));
    send_item(put_item(8'hFF));
    send_item(put_item(8'h80));
    // Backspace blanks the cell just written.
    send_item(put_item(CHAR_BS));
    send_item(read_item(3));
    // Tab stops from column 3: the tenth one lands on the line end and wraps.
    send_item(put_item(CHAR_TAB));
    repeat (9) send_item(put_item(CHAR_TAB));
    // Backspace at column zero does nothing.
    send_item(put_item(CHAR_BS));
    send_item(put_item(8'h78));
    send_item(put_item(CHAR_CR));
    send_item(put_item(CHAR_LF));
    send_item(read_item(2));
    // Last index field value and the first one past the screen read zero.
    send_item(read_item(INDEX_MAX));
    send_item(read_item(CELL_COUNT));
    send_item(plain_item(KIND_SPARE));
    wait_drained();

    // Random phases, each under a new attribute, extremes included.
    write_attribute(8'h00);
    run_phase(PHASE_ITEMS);
    wait_drained();
    write_attribute(8'hFF);
    run_phase(PHASE_ITEMS);
    wait_drained();
    write_attribute(ATTR_W'($urandom));
    run_phase(PHASE_ITEMS);
    wait_drained();
    write_attribute(8'h5A);
    run_phase(PHASE_ITEMS);
    wait_drained();

    // Give a stray extra result time to show up before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk_i);
    mirror.check_drained();
    if (mirror.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_dp.sv
hw/rtl/text_console_writer.sv
tb/tcw_check_pkg.sv
tb/tb_text_console_writer.sv
